// ===== rtl/core/kfd_pkg.sv =====
// kfd_pkg: shared constants, types and control structs of the kiss frame decoder
// no dependencies

package kfd_pkg;

  // kiss special bytes
  localparam logic [7:0] KISS_FEND  = 8'hC0;
  localparam logic [7:0] KISS_FESC  = 8'hDB;
  localparam logic [7:0] KISS_TFEND = 8'hDC;
  localparam logic [7:0] KISS_TFESC = 8'hDD;

  // input function codes
  localparam logic FUNC_BYTE   = 1'b0;
  localparam logic FUNC_RESYNC = 1'b1;

  // frame store geometry
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;

  // default raw byte limit per frame, legal range 1 to STORE_DEPTH
  localparam int unsigned MAX_FRAME_DEF = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input transaction taken this cycle
    logic rd_en;    // read store at the readout index
    logic rd_next;  // advance readout index
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_ready;  // current input closes a frame that has bytes to emit
    logic rd_last;      // readout index sits on the final stored byte
  } dp_status_t;

endpackage

// ===== rtl/core/kiss_frame_decoder.sv =====
// kiss_frame_decoder: top level of the kiss deframer
// depends on kfd_pkg, kfd_ctrl and kfd_datapath

// The decoder takes raw bytes from a serial link (func_i = 0) and deframes them
// under kiss: 0xC0 delimits frames, 0xDB escapes the next byte, 0xDC and 0xDD
// stand for 0xC0 and 0xDB. Bytes before the first delimiter are dropped. Each
// delimiter closes a frame, and a frame that was synced, stayed within
// MAX_FRAME raw bytes and unescapes to at least one byte is handed out one
// byte per output transaction, the last flagged with frame_last_o. An invalid
// escape keeps its byte, a trailing escape is discarded, and func_i = 1
// clears all frame and sync state. A byte transaction that does not close an
// emitting frame is taken without stall. A closing delimiter makes the input
// stall for the whole readout: for each frame byte a registered read of the
// 64 entry frame store, then the byte in the output register, held while the
// output is stalled. The store needs no clearing after reset.

module kiss_frame_decoder
  import kfd_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] rx_byte_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_last_o
);

  // command and status between controller and datapath
  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // controller: accepts input transactions, runs the readout sequence
  kfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: unescaping, frame store, counters and the output byte register
  kfd_datapath #(
    .MAX_FRAME (MAX_FRAME)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .rx_byte_i    (rx_byte_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .frame_byte_o (frame_byte_o),
    .frame_last_o (frame_last_o)
  );

endmodule

// ===== rtl/core/kfd_ctrl.sv =====
// kfd_ctrl: controller state machine, sequences input acceptance and frame readout
// depends on kfd_pkg

module kfd_ctrl
  import kfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.frame_ready) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = sts_i.rd_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_OUT: begin
        out_valid_o   = 1'b1;
        cmd_o.rd_next = !out_stall_i && !sts_i.rd_last;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // a readout always runs read then present
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_OUT))
    else $error("kfd_ctrl: read not followed by output");

  // the final byte handed over returns control to input acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !out_stall_i && sts_i.rd_last) |=> (state_q == ST_IDLE))
    else $error("kfd_ctrl: no return to idle after last byte");

  // a presented byte waits under stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_stall_i) |=> (state_q == ST_OUT))
    else $error("kfd_ctrl: output dropped under stall");

endmodule

// ===== rtl/core/kfd_datapath.sv =====
// kfd_datapath: frame store, unescape logic, counters, sync flags and readout index
// depends on kfd_pkg

module kfd_datapath
  import kfd_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       func_i,
  input  logic [7:0] rx_byte_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t sts_o,
  output logic [7:0] frame_byte_o,
  output logic       frame_last_o
);

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_FRAME);

  logic [7:0]       store_mem [STORE_DEPTH];
  logic [CNT_W-1:0] raw_count_q, raw_count_d;
  logic [CNT_W-1:0] stored_count_q, stored_count_d;
  logic             synced_q, synced_d;
  logic             oversized_q, oversized_d;
  logic             esc_q, esc_d;
  logic [CNT_W-1:0] rd_len_q, rd_len_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [7:0]       rdata_q;

  logic             is_fend;
  logic             emit_ok;
  logic             wr_en;
  logic [7:0]       wr_data;

  assign is_fend = (func_i == FUNC_BYTE) && (rx_byte_i == KISS_FEND);
  assign emit_ok = synced_q && !oversized_q && (stored_count_q != '0);

  assign sts_o.frame_ready = is_fend && emit_ok;
  assign sts_o.rd_last     = (rd_idx_q + CNT_W'(1)) == rd_len_q;

  always_comb begin
    raw_count_d    = raw_count_q;
    stored_count_d = stored_count_q;
    synced_d       = synced_q;
    oversized_d    = oversized_q;
    esc_d          = esc_q;
    rd_len_d       = rd_len_q;
    rd_idx_d       = rd_idx_q;
    wr_en          = 1'b0;
    wr_data        = rx_byte_i;

    if (cmd_i.accept) begin
      if (func_i == FUNC_RESYNC) begin
        raw_count_d    = '0;
        stored_count_d = '0;
        esc_d          = 1'b0;
        synced_d       = 1'b0;
        oversized_d    = 1'b0;
      end else if (is_fend) begin
        rd_len_d       = stored_count_q;
        rd_idx_d       = '0;
        raw_count_d    = '0;
        stored_count_d = '0;
        esc_d          = 1'b0;
        synced_d       = 1'b1;
        oversized_d    = 1'b0;
      end else if (synced_q && !oversized_q) begin
        if (raw_count_q >= LIMIT) begin
          raw_count_d    = '0;
          stored_count_d = '0;
          esc_d          = 1'b0;
          oversized_d    = 1'b1;
        end else begin
          raw_count_d = raw_count_q + CNT_W'(1);
          if (esc_q) begin
            esc_d = 1'b0;
            wr_en = 1'b1;
            if (rx_byte_i == KISS_TFEND) begin
              wr_data = KISS_FEND;
            end else if (rx_byte_i == KISS_TFESC) begin
              wr_data = KISS_FESC;
            end
          end else if (rx_byte_i == KISS_FESC) begin
            esc_d = 1'b1;
          end else begin
            wr_en = 1'b1;
          end
          if (wr_en) begin
            stored_count_d = stored_count_q + CNT_W'(1);
          end
        end
      end
    end

    if (cmd_i.rd_next) begin
      rd_idx_d = rd_idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_count_q    <= '0;
      stored_count_q <= '0;
      synced_q       <= 1'b0;
      oversized_q    <= 1'b0;
      esc_q          <= 1'b0;
      rd_len_q       <= '0;
      rd_idx_q       <= '0;
    end else begin
      raw_count_q    <= raw_count_d;
      stored_count_q <= stored_count_d;
      synced_q       <= synced_d;
      oversized_q    <= oversized_d;
      esc_q          <= esc_d;
      rd_len_q       <= rd_len_d;
      rd_idx_q       <= rd_idx_d;
    end
  end

  // frame store, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[stored_count_q[ADDR_W-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= store_mem[rd_idx_q[ADDR_W-1:0]];
    end
  end

  assign frame_byte_o = rdata_q;
  assign frame_last_o = sts_o.rd_last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_count_q <= raw_count_q)
    else $error("kfd_datapath: more stored than raw bytes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    raw_count_q <= LIMIT)
    else $error("kfd_datapath: raw count past frame limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!synced_q || oversized_q) |-> (raw_count_q == '0 && !esc_q))
    else $error("kfd_datapath: frame state held while discarding");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_next |=> (rd_idx_q < rd_len_q))
    else $error("kfd_datapath: readout index beyond frame length");

endmodule

// ===== bench/kiss_frame_decoder_test.sv =====
// kiss_frame_decoder_test: self-checking bench for the kiss frame decoder
// depends on kfd_pkg and kiss_frame_decoder; drives raw link bytes, checks
// every deframed output byte against an in-bench model of the deframer

module kiss_frame_decoder_test;
  import kfd_pkg::*;

  localparam int unsigned FRAME_LIMIT = MAX_FRAME_DEF;
  localparam int ITEM_TARGET = 360;   // input transactions to send in total
  localparam int IDLE_LIMIT = 3000;   // cycles with no transaction before giving up
  localparam int TAIL_CYCLES = 40;    // quiet time after the last expected byte
  localparam int LONG_HOLD = 300;     // receiver hold-off that backs up the decoder

  // one raw item for the link side
  typedef struct {
    logic       fn;
    logic [7:0] value;
    bit         drain;  // hold this item back until every pending byte is out
  } link_item_t;

  // one deframed byte as it should leave the decoder
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_out_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       func_i = FUNC_BYTE;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] frame_byte_o;
  logic       frame_last_o;

  kiss_frame_decoder #(
    .MAX_FRAME(FRAME_LIMIT)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_byte_o(frame_byte_o),
    .frame_last_o(frame_last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // stimulus and expectation stores
  link_item_t link_q[$];
  frame_out_t frame_bytes_q[$];
  bit         drain_next = 1'b0;

  // deframer model state
  logic [7:0]  rx_frame[STORE_DEPTH];
  int unsigned rx_raw_cnt = 0;
  int unsigned rx_kept_cnt = 0;
  bit          rx_synced = 1'b0;
  bit          rx_dropping = 1'b0;
  bit          rx_escaped = 1'b0;

  // bookkeeping
  int n_in_acc = 0;
  int n_out_acc = 0;
  int n_errors = 0;
  int n_frames_out = 0;
  int n_frames_dropped = 0;
  int n_resyncs = 0;
  int n_escapes = 0;
  int n_long_holds = 0;
  int n_drains = 0;

  // model: one accepted link transaction, pushes the bytes it releases
  function automatic void deframe_item(input logic fn, input logic [7:0] b);
    int unsigned i;
    if (fn == FUNC_RESYNC) begin
      rx_raw_cnt = 0;
      rx_kept_cnt = 0;
      rx_escaped = 1'b0;
      rx_synced = 1'b0;
      rx_dropping = 1'b0;
      n_resyncs++;
      return;
    end
    if (b == KISS_FEND) begin
      // a delimiter closes the frame; only a clean, synced, nonempty one is released
      if (rx_synced && !rx_dropping && rx_raw_cnt > 0) begin
        for (i = 0; i < rx_kept_cnt; i++)
          frame_bytes_q.push_back('{rx_frame[i[ADDR_W-1:0]], (i + 1 == rx_kept_cnt)});
        if (rx_kept_cnt > 0) n_frames_out++;
      end
      rx_raw_cnt = 0;
      rx_kept_cnt = 0;
      rx_escaped = 1'b0;
      rx_synced = 1'b1;
      rx_dropping = 1'b0;
      return;
    end
    if (!rx_synced || rx_dropping) return;
    if (rx_raw_cnt >= FRAME_LIMIT) begin
      // one raw byte past the limit drops the frame up to the next delimiter
      rx_raw_cnt = 0;
      rx_kept_cnt = 0;
      rx_escaped = 1'b0;
      rx_dropping = 1'b1;
      n_frames_dropped++;
      return;
    end
    rx_raw_cnt++;
    if (rx_escaped) begin
      rx_escaped = 1'b0;
      n_escapes++;
      if (b == KISS_TFEND) b = KISS_FEND;
      else if (b == KISS_TFESC) b = KISS_FESC;
    end else if (b == KISS_FESC) begin
      rx_escaped = 1'b1;
      return;
    end
    if (rx_kept_cnt < STORE_DEPTH) begin
      rx_frame[rx_kept_cnt[ADDR_W-1:0]] = b;
      rx_kept_cnt++;
    end
  endfunction

  // stimulus helpers
  function automatic void add_item(input logic fn, input logic [7:0] b);
    link_q.push_back('{fn, b, drain_next});
    drain_next = 1'b0;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == KISS_FEND);
    return b;
  endfunction

  // frame of exactly raw_len raw bytes, closed by a delimiter
  function automatic void add_frame(input int raw_len);
    int left;
    int r;
    left = raw_len;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 12 && left >= 2) begin
        add_item(FUNC_BYTE, KISS_FESC);
        case ($urandom_range(0, 3))
          0: add_item(FUNC_BYTE, KISS_TFEND);
          1: add_item(FUNC_BYTE, KISS_TFESC);
          default: add_item(FUNC_BYTE, plain_byte());
        endcase
        left -= 2;
      end else begin
        if (r < 15) add_item(FUNC_BYTE, KISS_FESC);
        else if (r < 20) add_item(FUNC_BYTE, r[0] ? KISS_TFEND : KISS_TFESC);
        else add_item(FUNC_BYTE, plain_byte());
        left--;
      end
    end
    add_item(FUNC_BYTE, KISS_FEND);
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // link-side driver: feeds link_q one transaction at a time
  int in_gap = 0;
  bit in_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    link_item_t item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      func_i <= FUNC_BYTE;
      rx_byte_i <= 8'h00;
      in_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        deframe_item(func_i, rx_byte_i);
        n_in_acc++;
      end
      if (in_valid_i && in_stall_o) begin
        // stalled: payload stays put
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (link_q.size() > 0 && !(link_q[0].drain && frame_bytes_q.size() != 0)) begin
        item = link_q.pop_front();
        if (item.drain) n_drains++;
        if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
        in_valid_i <= 1'b1;
        func_i <= item.fn;
        rx_byte_i <= item.value;
        in_gap <= pick_gap(in_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output-side stall: random short and long gaps, calm stretches, and
  // two long hold-offs so the decoder backs up into its input
  int  stall_left = 0;
  bit  out_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if ($urandom_range(0, 99) == 0) out_calm = !out_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ((n_long_holds == 0 && n_out_acc >= 20) ||
                   (n_long_holds == 1 && n_out_acc >= 200)) begin
        n_long_holds++;
        stall_left = LONG_HOLD - 1;
        out_stall_i <= 1'b1;
      end else if (!out_calm && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 24);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // output monitor: every accepted byte against the oldest expectation
  always @(posedge clk_i) begin
    frame_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_out_acc++;
      if (frame_bytes_q.size() == 0) begin
        if (n_errors < 10)
          $display("unexpected output byte %02h last %0b", frame_byte_o, frame_last_o);
        n_errors++;
      end else begin
        want = frame_bytes_q.pop_front();
        if (frame_byte_o !== want.value || frame_last_o !== want.last) begin
          if (n_errors < 10)
            $display("mismatch at output %0d: expected byte %02h last %0b, got byte %02h last %0b",
                     n_out_acc, want.value, want.last, frame_byte_o, frame_last_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog: too long without any transaction on either side
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles without a transaction", idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int n_total;

    // directed part
    add_item(FUNC_BYTE, KISS_FESC);          // noise before any delimiter, ignored
    add_item(FUNC_BYTE, KISS_FEND);          // first delimiter only syncs
    add_item(FUNC_BYTE, KISS_FEND);          // back-to-back delimiters, empty frame
    add_item(FUNC_BYTE, 8'h00);
    add_item(FUNC_BYTE, 8'hFF);
    add_item(FUNC_BYTE, KISS_TFEND);         // bare transposed byte stays as is
    add_item(FUNC_BYTE, KISS_FESC);
    add_item(FUNC_BYTE, KISS_TFEND);         // escaped delimiter
    add_item(FUNC_BYTE, KISS_FESC);
    add_item(FUNC_BYTE, KISS_TFESC);         // escaped escape
    add_item(FUNC_BYTE, KISS_FESC);
    add_item(FUNC_BYTE, 8'h41);              // invalid escape keeps the byte
    add_item(FUNC_BYTE, KISS_FESC);
    add_item(FUNC_BYTE, KISS_FESC);          // escape of an escape, kept literally
    add_item(FUNC_BYTE, KISS_FEND);
    add_item(FUNC_BYTE, KISS_FESC);          // frame that unescapes to nothing
    add_item(FUNC_BYTE, KISS_FEND);
    add_item(FUNC_BYTE, 8'h55);
    add_item(FUNC_BYTE, KISS_FESC);          // trailing escape is discarded
    add_item(FUNC_BYTE, KISS_FEND);
    add_item(FUNC_RESYNC, 8'hA5);            // resync drops sync
    add_item(FUNC_BYTE, 8'h34);              // ignored until the next delimiter
    add_item(FUNC_BYTE, KISS_FEND);

    // random part: first drains, then the frame length extremes
    drain_next = 1'b1;
    add_frame(FRAME_LIMIT);
    add_frame(FRAME_LIMIT + 1);
    add_frame(1);
    while (link_q.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 3) drain_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 75) begin
        r = $urandom_range(0, 99);
        if (r < 85) add_frame($urandom_range(1, 12));
        else if (r < 97) add_frame($urandom_range(13, 40));
        else add_frame($urandom_range(FRAME_LIMIT - 2, FRAME_LIMIT + 6));
      end else if (r < 85) begin
        // noise, delimiters included
        repeat ($urandom_range(1, 4)) add_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
      end else if (r < 92) begin
        add_item(FUNC_RESYNC, 8'($urandom_range(0, 255)));
      end else begin
        if (r[0]) add_item(FUNC_BYTE, KISS_FESC);
        add_item(FUNC_BYTE, KISS_FEND);
      end
    end
    n_total = link_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_in_acc < n_total) @(posedge clk_i);
    while (frame_bytes_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (frame_bytes_q.size() != 0) n_errors++;
    $display("sent %0d link transactions (%0d resyncs, %0d escapes), checked %0d frame bytes",
             n_in_acc, n_resyncs, n_escapes, n_out_acc);
    $display("%0d frames released, %0d oversized dropped, %0d long holds, %0d drains, %0d errors",
             n_frames_out, n_frames_dropped, n_long_holds, n_drains, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
